[rtl/core/lsbu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbu_pkg
// types and constants shared by the burst-sorted lottery scheduler
// ----------------------------------------------------------------------------
package lsbu_pkg;

    localparam int MAX_PROCS_DEF = 16;
    localparam int ID_W   = 5;
    localparam int BURST_W = 16;
    localparam int TKT_W  = 16;
    localparam int TOT_W  = 20;
    localparam int RND_W  = 31;
    localparam int TIME_W = 32;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef struct packed {
        logic               func;
        logic [BURST_W-1:0] burst_time;
        logic [TKT_W-1:0]   ticket_count;
        logic [RND_W-1:0]   random_word;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0]   selected_id;
        logic              cpu_idle;
        logic              all_done;
        logic [TIME_W-1:0] tick_time;
        logic              table_full;
    } t_out_item;

    // one table entry as held in a cell
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [BURST_W-1:0] burst;
        logic [TKT_W-1:0]   tickets;
        logic [BURST_W-1:0] left;
    } t_entry;

    // command broadcast from the controller to every cell
    typedef struct packed {
        logic               insert;
        logic [BURST_W-1:0] burst;
        t_entry             new_entry;
        logic               scan;
        logic [TOT_W-1:0]   winning;
    } t_cell_cmd;

    // value handed from one cell to the next along the chain, for insert and for scan
    typedef struct packed {
        logic               shift_ok;
        t_entry             carry;
        logic               active;
        logic [TOT_W-1:0]   sum;
        logic               found;
        logic [ID_W-1:0]    win_id;
    } t_link;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SCAN,
        ST_RESULT
    } t_state;

endpackage

[rtl/core/lsbu_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbu_cell
// one table slot: sorted insert by shifting, and one stage of the ticket scan
// ----------------------------------------------------------------------------
module lsbu_cell
    import lsbu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_valid_slot,
    input  t_cell_cmd i_cmd,
    input  t_link     i_link,
    output t_link     o_link
);

    t_entry r_entry;
    logic   r_found;
    logic   r_active;
    logic   [TOT_W-1:0] r_sum;
    logic   [ID_W-1:0]  r_win_id;

    logic   mine_bigger;
    logic   live;
    logic   [TOT_W-1:0] n_sum;
    logic   hit;

    // slot holds an entry that sorts after the new one
    assign mine_bigger = i_valid_slot && (r_entry.burst > i_cmd.burst);
    assign live = i_valid_slot && (r_entry.left != '0);
    assign n_sum = i_link.sum + (live ? TOT_W'(r_entry.tickets) : '0);
    assign hit = !i_link.found && live && (i_cmd.winning < n_sum);

    always_ff @(posedge i_clk) begin
        if (i_cmd.insert) begin
            // left neighbor also bigger: take its entry, else the first bigger or first empty slot gets the new one
            if (i_link.shift_ok) begin
                r_entry <= i_link.carry;
            end else if (mine_bigger || !i_valid_slot) begin
                if (!i_valid_slot && !i_link.shift_ok && i_link.active) begin
                    r_entry <= r_entry;
                end else begin
                    r_entry <= i_cmd.new_entry;
                end
            end
        end else if (i_cmd.scan && hit) begin
            r_entry.left <= r_entry.left - 1'b1;
        end
        r_found  <= i_link.found || hit;
        r_active <= i_link.active || live;
        r_sum    <= n_sum;
        r_win_id <= hit ? r_entry.id : i_link.win_id;
    end

    always_comb begin
        o_link = '0;
        if (i_cmd.insert) begin
            o_link.shift_ok = i_link.shift_ok || mine_bigger;
            o_link.carry    = r_entry;
            // marks that the new entry was already placed here or upstream
            o_link.active   = i_link.active || i_link.shift_ok || mine_bigger
                              || !i_valid_slot;
        end else begin
            o_link.found  = r_found;
            o_link.active = r_active;
            o_link.sum    = r_sum;
            o_link.win_id = r_win_id;
        end
    end

endmodule

[rtl/core/lsbu_mod.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbu_mod
// restoring remainder unit, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lsbu_mod
    import lsbu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [RND_W-1:0] i_dividend,
    input  logic [TOT_W-1:0] i_divisor,
    output logic             o_done,
    output logic [TOT_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(RND_W + 1);

    logic [RND_W-1:0] r_num;
    logic [TOT_W:0]   r_rem;
    logic [TOT_W-1:0] r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [TOT_W+1:0] n_try;
    logic [TOT_W:0]   n_shift;

    assign n_shift = {r_rem[TOT_W-1:0], r_num[RND_W-1]};
    assign n_try   = {1'b0, n_shift} - {2'b00, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(RND_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_num <= {r_num[RND_W-2:0], 1'b0};
            r_rem <= n_try[TOT_W+1] ? n_shift : n_try[TOT_W:0];
        end
    end

    assign o_done = !r_busy;
    assign o_rem  = r_rem[TOT_W-1:0];

endmodule

[rtl/core/lottery_scheduler_sorted_by_burst_unit.sv]
`timescale 1ns / 1ps
// a load is answered from ST_RESULT once the output is free; the cells shift on that same edge
// a tick starts the remainder unit, waits while it works through every bit of the random
// word, takes the remainder into r_win, then runs the scan wave along the cell chain
// one item in flight at a time: the next item is taken only back in ST_IDLE, after the
// result is registered; a result still waiting at the output holds the last step
// synchronous active-low reset clears the count, ticket total, time and control only
// ----------------------------------------------------------------------------
// lottery_scheduler_sorted_by_burst_unit
// burst-sorted process table in a chain of cells with a lottery pick per tick
// ----------------------------------------------------------------------------
module lottery_scheduler_sorted_by_burst_unit
    import lsbu_pkg::*;
#(
    parameter int MAX_PROCS = MAX_PROCS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int CNT_W  = $clog2(MAX_PROCS + 1);
    localparam int STEP_W = $clog2(MAX_PROCS + 2);

    t_state r_state, n_state;
    t_in_item r_item;
    logic [CNT_W-1:0]  r_count;
    logic [TOT_W-1:0]  r_total;
    logic [TIME_W-1:0] r_time;
    logic [STEP_W-1:0] r_step;
    logic [TOT_W-1:0]  r_win;
    t_out_item r_out, n_out;
    t_out_item r_tick, n_tick;
    logic r_out_valid;

    t_cell_cmd cmd;
    t_link links [MAX_PROCS+1];
    logic mod_start, mod_done;
    logic [TOT_W-1:0] mod_rem;
    logic accept, is_load, full, out_free;

    assign accept   = i_in_valid && !o_in_stall;
    assign is_load  = (r_item.func == FUNC_LOAD);
    assign full     = (r_count >= CNT_W'(MAX_PROCS));
    assign out_free = !r_out_valid || !i_out_stall;

    lsbu_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (r_item.random_word),
        .i_divisor  (r_total),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    assign links[0] = '0;

    for (genvar g = 0; g < MAX_PROCS; g++) begin : g_cell
        lsbu_cell u_cell (
            .i_clk        (i_clk),
            .i_valid_slot (CNT_W'(g) < r_count),
            .i_cmd        (cmd),
            .i_link       (links[g]),
            .o_link       (links[g+1])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (accept) n_state = (i_in_item.func == FUNC_LOAD) ? ST_RESULT : ST_DIV;
            ST_DIV:    if (!mod_start && mod_done) n_state = ST_SCAN;
            ST_SCAN:   if (r_step == STEP_W'(MAX_PROCS)) n_state = ST_RESULT;
            ST_RESULT: if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        mod_start = 1'b0;
        o_in_stall = (r_state != ST_IDLE);
        unique case (r_state)
            ST_DIV:  mod_start = (r_step == '0);
            ST_SCAN: begin
                cmd.scan    = (r_step == STEP_W'(MAX_PROCS));
                cmd.winning = (r_total == '0) ? '1 : r_win;
            end
            ST_RESULT: begin
                cmd.insert = is_load && !full && out_free;
                cmd.burst  = r_item.burst_time;
                cmd.new_entry.id      = ID_W'(r_count + 1'b1);
                cmd.new_entry.burst   = r_item.burst_time;
                cmd.new_entry.tickets = r_item.ticket_count;
                cmd.new_entry.left    = r_item.burst_time;
            end
            default: ;
        endcase
    end

    // tick outcome once the scan wave has reached the chain end
    always_comb begin
        n_tick = '0;
        n_tick.tick_time = r_time;
        if (!links[MAX_PROCS].active) begin
            n_tick.all_done = 1'b1;
        end else if (links[MAX_PROCS].found && r_total != '0) begin
            n_tick.selected_id = links[MAX_PROCS].win_id;
        end else begin
            n_tick.cpu_idle = 1'b1;
        end
    end

    always_comb begin
        if (is_load) begin
            n_out = '0;
            n_out.table_full = full;
        end else begin
            n_out = r_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_total     <= '0;
            r_time      <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_RESULT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_DIV: begin
                    if (r_step == '0) begin
                        r_step <= STEP_W'(1);
                    end else if (mod_done) begin
                        r_win  <= mod_rem;
                        r_step <= '0;
                    end
                end
                ST_SCAN: begin
                    // scan runs once the wave reaches the chain end, then commits
                    if (r_step == STEP_W'(MAX_PROCS)) begin
                        r_step <= '0;
                        r_tick <= n_tick;
                        if (links[MAX_PROCS].active) r_time <= r_time + 1'b1;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                ST_RESULT: begin
                    if (out_free) begin
                        r_out <= n_out;
                        if (is_load && !full) begin
                            r_count <= r_count + 1'b1;
                            r_total <= r_total + TOT_W'(r_item.ticket_count);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_item <= i_in_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
